// ===== sv/line_clip_color_interp_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the segment clipper
// Clocked implication checks that compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef LINE_CLIP_COLOR_INTERP_ASSERT_SVH
`define LINE_CLIP_COLOR_INTERP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define LCCI_ASSERT_IMP(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Next-cycle implication.
`define LCCI_ASSERT_NXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define LCCI_ASSERT_IMP(label, clk, rst, pre, post, msg)
`define LCCI_ASSERT_NXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== sv/lcci_pkg.sv =====
// ---------------------------------------------------------------------------
// lcci_pkg
// Shared types and constants of the segment clipper.
// ---------------------------------------------------------------------------
`default_nettype none

package lcci_pkg;

  // Window boundaries in the order they are tested.
  typedef enum logic [1:0] {
    BOUND_LEFT   = 2'd0,
    BOUND_RIGHT  = 2'd1,
    BOUND_BOTTOM = 2'd2,
    BOUND_TOP    = 2'd3
  } bound_t;

  localparam int NUM_BOUNDS = 4;
  localparam int COLOR_BITS = 8;

  // Interpolation lanes: x, y, red, green, blue for each clipped end.
  localparam int LANE_GROUP = 5;
  localparam int LANES      = 2 * LANE_GROUP;

  // Per-item flags that ride along with the divider row.
  typedef struct packed {
    logic             seen;
    logic             clip_end;
    logic             clip_start;
    logic [LANES-1:0] neg;
  } lane_flags_t;

endpackage

`default_nettype wire

// ===== sv/lcci_edge_cell.sv =====
// ---------------------------------------------------------------------------
// lcci_edge_cell
// One boundary test of the parametric clipper, registered.
// ---------------------------------------------------------------------------
`default_nettype none
`include "line_clip_color_interp_assert.svh"

module lcci_edge_cell #(
  parameter int              COORD_BITS = 16,
  parameter lcci_pkg::bound_t BOUND     = lcci_pkg::BOUND_LEFT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic signed [COORD_BITS-1:0] x0,
  input  logic signed [COORD_BITS-1:0] y0,
  input  logic signed [COORD_BITS-1:0] x1,
  input  logic signed [COORD_BITS-1:0] y1,
  input  logic                         vis_in,
  input  logic signed [COORD_BITS:0]   en_in,
  input  logic signed [COORD_BITS:0]   ed_in,
  input  logic signed [COORD_BITS:0]   ln_in,
  input  logic signed [COORD_BITS:0]   ld_in,
  output logic                         vis,
  output logic signed [COORD_BITS:0]   en,
  output logic signed [COORD_BITS:0]   ed,
  output logic signed [COORD_BITS:0]   ln,
  output logic signed [COORD_BITS:0]   ld
);

  localparam int PW = COORD_BITS + 1;
  localparam int EW = COORD_BITS + 2;
  localparam logic signed [EW-1:0] ONE = EW'(2 ** (COORD_BITS - 4));
  localparam bit X_AXIS = (BOUND == lcci_pkg::BOUND_LEFT) || (BOUND == lcci_pkg::BOUND_RIGHT);
  localparam bit LOW_SIDE = (BOUND == lcci_pkg::BOUND_LEFT) || (BOUND == lcci_pkg::BOUND_BOTTOM);

  logic signed [EW-1:0]   p0, p1, dp, den_w, num_w;
  logic signed [PW-1:0]   den, num;
  logic signed [2*PW-1:0] num_ld, ln_den, num_ed, en_den;
  logic                   gt_exit, gt_entry, den_pos, den_neg, reject;

  // Boundary test pair taken from the axis and side of this cell.
  always_comb begin
    p0    = X_AXIS ? EW'(x0) : EW'(y0);
    p1    = X_AXIS ? EW'(x1) : EW'(y1);
    dp    = p1 - p0;
    den_w = LOW_SIDE ? dp : -dp;
    num_w = LOW_SIDE ? (-ONE - p0) : (p0 - ONE);
    den   = $signed(den_w[PW-1:0]);
    num   = $signed(num_w[PW-1:0]);
  end

  // Cross products compare num/den against the exit and entry parameters.
  assign num_ld = num * ld_in;
  assign ln_den = ln_in * den;
  assign num_ed = num * ed_in;
  assign en_den = en_in * den;

  always_comb begin
    gt_exit  = num_ld > ln_den;
    gt_entry = num_ed > en_den;
    den_pos  = !den[PW-1] && (den != '0);
    den_neg  = den[PW-1];
    if (den_pos) begin
      reject = gt_exit;
    end else if (den_neg) begin
      reject = gt_entry;
    end else begin
      reject = !num[PW-1] && (num != '0);
    end
  end

  // Hand the parameters to the next boundary.
  always_ff @(posedge clk) begin
    if (advance) begin
      vis <= vis_in && !reject;
      en  <= en_in;
      ed  <= ed_in;
      ln  <= ln_in;
      ld  <= ld_in;
      if (vis_in && den_pos && gt_entry) begin
        en <= num;
        ed <= den;
      end
      if (vis_in && den_neg && gt_exit) begin
        ln <= -num;
        ld <= -den;
      end
    end
  end

  `LCCI_ASSERT_NXT(a_reject_sticky, clk, rst, advance && !vis_in, !vis, "rejected segment became visible")
  `LCCI_ASSERT_NXT(a_stall_hold, clk, rst, !advance, $stable(vis) && $stable(en) && $stable(ln), "edge cell changed during stall")

endmodule

`default_nettype wire

// ===== sv/lcci_div_cell.sv =====
// ---------------------------------------------------------------------------
// lcci_div_cell
// One quotient bit of a restoring divider, for all interpolation lanes.
// ---------------------------------------------------------------------------
`default_nettype none

module lcci_div_cell #(
  parameter int AW  = 37,
  parameter int DW  = 17,
  parameter int QB  = 17,
  parameter int BIT = 0
) (
  input  logic                                  clk,
  input  logic                                  advance,
  input  logic [lcci_pkg::LANES-1:0][AW-1:0]    rem_in,
  input  logic [lcci_pkg::LANES-1:0][QB-1:0]    quo_in,
  input  logic [lcci_pkg::LANES-1:0][DW-1:0]    div_in,
  output logic [lcci_pkg::LANES-1:0][AW-1:0]    rem,
  output logic [lcci_pkg::LANES-1:0][QB-1:0]    quo,
  output logic [lcci_pkg::LANES-1:0][DW-1:0]    div
);

  logic [lcci_pkg::LANES-1:0][AW-1:0] rem_next;
  logic [lcci_pkg::LANES-1:0][QB-1:0] quo_next;

  // Subtract the shifted divisor where it fits and set this quotient bit.
  always_comb begin
    logic [AW-1:0] trial;
    logic          fits;
    for (int i = 0; i < lcci_pkg::LANES; i++) begin
      trial       = AW'(div_in[i]) << BIT;
      fits        = rem_in[i] >= trial;
      rem_next[i] = fits ? (rem_in[i] - trial) : rem_in[i];
      quo_next[i] = quo_in[i] | (fits ? (QB'(1) << BIT) : QB'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem <= rem_next;
      quo <= quo_next;
      div <= div_in;
    end
  end

endmodule

`default_nettype wire

// ===== sv/line_clip_color_interp.sv =====
// ---------------------------------------------------------------------------
// line_clip_color_interp
// Clips a 2D segment to the window [-1, 1] and interpolates its end colors.
// ---------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: one segment with end colors
//  m_*      out  m_tvalid/m_tready  m_tdata: clipped segment, m_tuser: seen
//
// A new word is taken every cycle while the output word is not held. The pipeline
// is four boundary cells, one setup stage, one divider cell per quotient bit,
// and the output register.
// The pipeline moves as one: it stalls only while the output word is held.
// Reset clears the valid bits and the output valid; payload is not reset.
`default_nettype none
`include "line_clip_color_interp_assert.svh"

module line_clip_color_interp #(
  parameter int COORD_BITS      = 16,
  parameter int COLOR_FRAC_BITS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // start_x, start_y, end_x, end_y, start_red, start_green, start_blue,
  // end_red, end_green, end_blue
  input  logic [((4*COORD_BITS+48+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // clip_start_x, clip_start_y, clip_end_x, clip_end_y, clip_start_red,
  // clip_start_green, clip_start_blue, clip_end_red, clip_end_green, clip_end_blue
  output logic [((4*COORD_BITS+6*(8+COLOR_FRAC_BITS)+7)/8)*8-1:0] m_tdata,
  // seen
  output logic [0:0] m_tuser
);

  localparam int C      = COORD_BITS;
  localparam int F      = COLOR_FRAC_BITS;
  localparam int CW     = lcci_pkg::COLOR_BITS + F;
  localparam int VW     = ((C > CW) ? C : CW) + 1;
  localparam int AW     = VW + C + 2;
  localparam int DW     = C + 1;
  localparam int QB     = VW;
  localparam int NB     = lcci_pkg::NUM_BOUNDS;
  localparam int NS     = NB + 1 + QB;
  localparam int RAW_W  = 4 * C + 6 * lcci_pkg::COLOR_BITS;
  localparam int OUT_TW = ((4 * C + 6 * CW + 7) / 8) * 8;
  localparam int LN     = lcci_pkg::LANES;
  localparam int GRP    = lcci_pkg::LANE_GROUP;

  // Value of one lane at the start or far end, taken from a raw segment word.
  function automatic logic signed [VW-1:0] lane_base(logic [RAW_W-1:0] r, int g, bit far);
    logic signed [C-1:0] cv;
    logic [7:0]          colv;
    int                  ci;
    if (g < 2) begin
      ci = g + (far ? 2 : 0);
      cv = $signed(r[ci*C +: C]);
      lane_base = VW'(cv);
    end else begin
      ci = g - 2 + (far ? 3 : 0);
      colv = r[4*C + 8*ci +: 8];
      lane_base = $signed(VW'(colv) << F);
    end
  endfunction

  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // Raw segment words and valid bits travel alongside every stage.
  logic [RAW_W-1:0] raw [NS];
  logic [NS-1:0]    vld;

  always_ff @(posedge clk) begin
    if (advance) begin
      raw[0] <= s_tdata[RAW_W-1:0];
      for (int i = 1; i < NS; i++) begin
        raw[i] <= raw[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NS-2:0], s_tvalid};
    end
  end

  // Chain of boundary cells.
  logic [RAW_W-1:0]    e_raw [NB];
  logic                e_vis_in [NB];
  logic signed [C:0]   e_en_in [NB], e_ed_in [NB], e_ln_in [NB], e_ld_in [NB];
  logic                e_vis [NB];
  logic signed [C:0]   e_en [NB], e_ed [NB], e_ln [NB], e_ld [NB];

  assign e_raw[0]    = s_tdata[RAW_W-1:0];
  assign e_vis_in[0] = 1'b1;
  assign e_en_in[0]  = '0;
  assign e_ed_in[0]  = (C+1)'(1);
  assign e_ln_in[0]  = (C+1)'(1);
  assign e_ld_in[0]  = (C+1)'(1);

  for (genvar k = 0; k < NB; k++) begin : g_edge
    if (k > 0) begin : g_link
      assign e_raw[k]    = raw[k-1];
      assign e_vis_in[k] = e_vis[k-1];
      assign e_en_in[k]  = e_en[k-1];
      assign e_ed_in[k]  = e_ed[k-1];
      assign e_ln_in[k]  = e_ln[k-1];
      assign e_ld_in[k]  = e_ld[k-1];
    end
    lcci_edge_cell #(
      .COORD_BITS (C),
      .BOUND      (lcci_pkg::bound_t'(k))
    ) u_edge (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .x0      (e_raw[k][C-1:0]),
      .y0      (e_raw[k][2*C-1:C]),
      .x1      (e_raw[k][3*C-1:2*C]),
      .y1      (e_raw[k][4*C-1:3*C]),
      .vis_in  (e_vis_in[k]),
      .en_in   (e_en_in[k]),
      .ed_in   (e_ed_in[k]),
      .ln_in   (e_ln_in[k]),
      .ld_in   (e_ld_in[k]),
      .vis     (e_vis[k]),
      .en      (e_en[k]),
      .ed      (e_ed[k]),
      .ln      (e_ln[k]),
      .ld      (e_ld[k])
    );
  end

  // Setup: dividend 2*delta*n + d and divisor 2*d for each lane.
  logic [LN-1:0][AW-1:0] st_rem [QB+1];
  logic [LN-1:0][QB-1:0] st_quo [QB+1];
  logic [LN-1:0][DW-1:0] st_div [QB+1];
  lcci_pkg::lane_flags_t fl [QB+1];
  logic [LN-1:0][AW-1:0] a_val;
  logic [LN-1:0][C-1:0]  lane_d;

  always_comb begin
    logic signed [VW-1:0]  b0, b1, delta;
    logic [C-1:0]          n;
    logic signed [VW+C:0]  prod;
    for (int i = 0; i < LN; i++) begin
      b0        = lane_base(raw[NB-1], i % GRP, 1'b0);
      b1        = lane_base(raw[NB-1], i % GRP, 1'b1);
      delta     = b1 - b0;
      n         = (i < GRP) ? e_ln[NB-1][C-1:0] : e_en[NB-1][C-1:0];
      lane_d[i] = (i < GRP) ? e_ld[NB-1][C-1:0] : e_ed[NB-1][C-1:0];
      prod      = delta * $signed({1'b0, n});
      a_val[i]  = {prod, 1'b0} + AW'(lane_d[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fl[0].seen       <= e_vis[NB-1];
      fl[0].clip_end   <= e_ln[NB-1] < e_ld[NB-1];
      fl[0].clip_start <= e_en[NB-1] > 0;
      for (int i = 0; i < LN; i++) begin
        st_rem[0][i]  <= a_val[i] ^ {AW{a_val[i][AW-1]}};
        st_div[0][i]  <= {lane_d[i], 1'b0};
        st_quo[0][i]  <= '0;
        fl[0].neg[i]  <= a_val[i][AW-1];
      end
    end
  end

  // Divider row: one quotient bit per cell, most significant first.
  for (genvar j = 0; j < QB; j++) begin : g_div
    lcci_div_cell #(
      .AW  (AW),
      .DW  (DW),
      .QB  (QB),
      .BIT (QB - 1 - j)
    ) u_div (
      .clk     (clk),
      .advance (advance),
      .rem_in  (st_rem[j]),
      .quo_in  (st_quo[j]),
      .div_in  (st_div[j]),
      .rem     (st_rem[j+1]),
      .quo     (st_quo[j+1]),
      .div     (st_div[j+1])
    );

    always_ff @(posedge clk) begin
      if (advance) begin
        fl[j+1] <= fl[j];
      end
    end
  end

  // Final values: restore the quotient sign and add the start value.
  logic [LN-1:0][VW:0]   val;
  logic [OUT_TW-1:0]     out_word;
  lcci_pkg::lane_flags_t lf;
  logic [RAW_W-1:0]      rl;
  logic                  use_s, use_e;

  always_comb begin
    logic signed [VW-1:0] b0;
    logic signed [QB:0]   qs;
    logic [7:0]           cs0, ce0;
    lf    = fl[QB];
    rl    = raw[NS-1];
    use_s = lf.seen && lf.clip_start;
    use_e = lf.seen && lf.clip_end;
    for (int i = 0; i < LN; i++) begin
      b0     = lane_base(rl, i % GRP, 1'b0);
      qs     = $signed({1'b0, st_quo[QB][i]} ^ {(QB+1){lf.neg[i]}});
      val[i] = $signed({b0[VW-1], b0}) + qs;
    end
    out_word = '0;
    out_word[C-1:0]     = use_s ? val[GRP][C-1:0]   : rl[C-1:0];
    out_word[2*C-1:C]   = use_s ? val[GRP+1][C-1:0] : rl[2*C-1:C];
    out_word[3*C-1:2*C] = use_e ? val[0][C-1:0]     : rl[3*C-1:2*C];
    out_word[4*C-1:3*C] = use_e ? val[1][C-1:0]     : rl[4*C-1:3*C];
    for (int k = 0; k < 3; k++) begin
      cs0 = rl[4*C + 8*k +: 8];
      ce0 = rl[4*C + 24 + 8*k +: 8];
      out_word[4*C + CW*k +: CW]     = use_s ? val[GRP+2+k][CW-1:0] : (CW'(cs0) << F);
      out_word[4*C + CW*(3+k) +: CW] = use_e ? val[2+k][CW-1:0]     : (CW'(ce0) << F);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata    <= out_word;
      m_tuser[0] <= lf.seen;
    end
  end

  `LCCI_ASSERT_NXT(a_out_fill, clk, rst, vld[NS-1] && advance, m_tvalid, "finished word was dropped")
  `LCCI_ASSERT_NXT(a_stall_hold, clk, rst, !advance, $stable(vld), "pipeline moved during stall")
  `LCCI_ASSERT_NXT(a_seen_flag, clk, rst, advance && vld[NS-1], m_tuser[0] == $past(lf.seen), "seen flag mismatch")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// Segment clipper testbench
// Drives segments with end colors into the clipper and checks each clipped
// word against a built-in Liang-Barsky predictor that uses exact rationals.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE      = 4096;
  localparam int     N_RANDOM = 830;
  localparam int     QUIET_LO = 300;
  localparam int     QUIET_HI = 650;
  localparam int     WATCHDOG = 5000;
  localparam string  CNAME [3] = '{"red", "green", "blue"};

  typedef struct {
    logic             seen;
    logic signed [15:0] sx, sy, ex, ey;
    logic [11:0]      sc[3];
    logic [11:0]      ec[3];
  } clip_t;

  logic         clk, rst;
  logic         s_tvalid, s_tready;
  logic [111:0] s_tdata;
  logic         m_tvalid, m_tready;
  logic [135:0] m_tdata;
  logic [0:0]   m_tuser;

  logic [111:0] segments_q[$];
  clip_t        clipped_q[$];
  int           errors, n_sent, n_got, n_seen, cycle, idle_gap;
  bit           stim_done;

  line_clip_color_interp dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor(a / b) for b > 0.
  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // v0 + delta * n / d rounded to nearest, ties upward.
  function automatic longint lerp(longint v0, longint delta, longint n, longint d);
    return v0 + floor_div(2 * delta * n + d, 2 * d);
  endfunction

  // Clips one segment word and returns the expected output word.
  function automatic clip_t clip_segment(logic [111:0] w);
    clip_t  r;
    longint x0, y0, x1, y1, dx, dy, en, ed, ln, ld, pn, pd;
    longint den[4], num[4], c0[3], c1[3];
    bit     vis;
    x0 = longint'($signed(w[15:0]));
    y0 = longint'($signed(w[31:16]));
    x1 = longint'($signed(w[47:32]));
    y1 = longint'($signed(w[63:48]));
    dx = x1 - x0;
    dy = y1 - y0;
    for (int i = 0; i < 3; i++) begin
      c0[i] = longint'(w[64 + 8*i +: 8]) << 4;
      c1[i] = longint'(w[88 + 8*i +: 8]) << 4;
    end
    den[lcci_pkg::BOUND_LEFT]   = dx;  num[lcci_pkg::BOUND_LEFT]   = -ONE - x0;
    den[lcci_pkg::BOUND_RIGHT]  = -dx; num[lcci_pkg::BOUND_RIGHT]  = x0 - ONE;
    den[lcci_pkg::BOUND_BOTTOM] = dy;  num[lcci_pkg::BOUND_BOTTOM] = -ONE - y0;
    den[lcci_pkg::BOUND_TOP]    = -dy; num[lcci_pkg::BOUND_TOP]    = y0 - ONE;
    en = 0; ed = 1; ln = 1; ld = 1;
    vis = 1'b1;
    for (int b = 0; b < lcci_pkg::NUM_BOUNDS && vis; b++) begin
      if (den[b] > 0) begin
        if (num[b] * ld > ln * den[b]) vis = 1'b0;
        else if (num[b] * ed > en * den[b]) begin
          en = num[b]; ed = den[b];
        end
      end else if (den[b] < 0) begin
        pn = -num[b]; pd = -den[b];
        if (pn * ed < en * pd) vis = 1'b0;
        else if (pn * ld < ln * pd) begin
          ln = pn; ld = pd;
        end
      end else if (num[b] > 0) begin
        vis = 1'b0;
      end
    end
    r.seen = vis;
    r.sx = x0[15:0]; r.sy = y0[15:0]; r.ex = x1[15:0]; r.ey = y1[15:0];
    for (int i = 0; i < 3; i++) begin
      r.sc[i] = c0[i][11:0];
      r.ec[i] = c1[i][11:0];
    end
    if (vis && ln < ld) begin
      r.ex = 16'(lerp(x0, dx, ln, ld));
      r.ey = 16'(lerp(y0, dy, ln, ld));
      for (int i = 0; i < 3; i++) r.ec[i] = 12'(lerp(c0[i], c1[i] - c0[i], ln, ld));
    end
    if (vis && en > 0) begin
      r.sx = 16'(lerp(x0, dx, en, ed));
      r.sy = 16'(lerp(y0, dy, en, ed));
      for (int i = 0; i < 3; i++) r.sc[i] = 12'(lerp(c0[i], c1[i] - c0[i], en, ed));
    end
    return r;
  endfunction

  function automatic logic [111:0] pack_segment(int x0, int y0, int x1, int y1,
                                                logic [47:0] colors);
    return {colors, 16'(y1), 16'(x1), 16'(y0), 16'(x0)};
  endfunction

  // Appends one segment word to the stimulus queue.
  function automatic void add_segment(logic [111:0] w);
    segments_q = {segments_q, w};
  endfunction

  // A coordinate near the window, so most segments reach the clipping math.
  function automatic int near_coord();
    return $urandom_range(0, 12000) - 6000;
  endfunction

  function automatic bit idle_now();
    return !(cycle >= QUIET_LO && cycle < QUIET_HI) && ($urandom_range(0, 99) < 17);
  endfunction

  // Driver: records each accepted word, then presents the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        clipped_q = {clipped_q, clip_segment(s_tdata)};
        n_sent++;
      end
      if ((!s_tvalid || s_tready) && segments_q.size() > 0 && !idle_now()) begin
        s_tvalid <= 1'b1;
        s_tdata  <= segments_q.pop_front();
      end else if (!s_tvalid || s_tready) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compares each output word with the oldest expectation.
  always @(posedge clk) begin
    clip_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !idle_now();
      if (m_tvalid && m_tready) begin
        n_got++;
        if (clipped_q.size() == 0) begin
          $error("output word with no segment pending");
          errors++;
        end else begin
          e = clipped_q.pop_front();
          if (m_tuser[0]) n_seen++;
          if (m_tuser[0] !== e.seen) begin
            $error("seen: expected %0d, got %0d", e.seen, m_tuser[0]); errors++;
          end
          if (m_tdata[15:0] !== e.sx) begin
            $error("clip_start_x: expected %0d, got %0d", e.sx, $signed(m_tdata[15:0]));
            errors++;
          end
          if (m_tdata[31:16] !== e.sy) begin
            $error("clip_start_y: expected %0d, got %0d", e.sy, $signed(m_tdata[31:16]));
            errors++;
          end
          if (m_tdata[47:32] !== e.ex) begin
            $error("clip_end_x: expected %0d, got %0d", e.ex, $signed(m_tdata[47:32]));
            errors++;
          end
          if (m_tdata[63:48] !== e.ey) begin
            $error("clip_end_y: expected %0d, got %0d", e.ey, $signed(m_tdata[63:48]));
            errors++;
          end
          for (int i = 0; i < 3; i++) begin
            if (m_tdata[64 + 12*i +: 12] !== e.sc[i]) begin
              $error("clip_start_%s: expected %0d, got %0d",
                     CNAME[i], e.sc[i], m_tdata[64 + 12*i +: 12]);
              errors++;
            end
            if (m_tdata[100 + 12*i +: 12] !== e.ec[i]) begin
              $error("clip_end_%s: expected %0d, got %0d",
                     CNAME[i], e.ec[i], m_tdata[100 + 12*i +: 12]);
              errors++;
            end
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word while work remains.
  always @(posedge clk) begin
    cycle++;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (segments_q.size() == 0 && clipped_q.size() == 0 && !s_tvalid)) begin
      idle_gap <= 0;
    end else if (idle_gap >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_gap <= idle_gap + 1;
    end
  end

  initial begin
    logic [47:0] hues;
    rst = 1'b1;
    errors = 0; n_sent = 0; n_got = 0; n_seen = 0; cycle = 0; idle_gap = 0;
    // Directed: inside, crossing, outside, parallel, degenerate, touching, extremes.
    add_segment(pack_segment(-1000, -500, 2000, 1500, 48'hFFFFFF_000000));
    add_segment(pack_segment(-8192, 0, 8192, 0, 48'h000000_FFFFFF));
    add_segment(pack_segment(0, -8192, 0, 8192, 48'h123456_ABCDEF));
    add_segment(pack_segment(-8000, -6000, 7000, 9000, 48'hFF00FF_00FF00));
    add_segment(pack_segment(5000, -100, 6000, 100, 48'h808080_808080));
    add_segment(pack_segment(-5000, 5000, 5000, 5000, 48'h010203_040506));
    add_segment(pack_segment(100, 200, 100, 200, 48'hFFFFFF_FFFFFF));
    add_segment(pack_segment(5000, 5000, 5000, 5000, 48'h0F0F0F_F0F0F0));
    add_segment(pack_segment(4096, -8000, 4096, 8000, 48'hAA55AA_55AA55));
    add_segment(pack_segment(4096, 4096, 8000, 8000, 48'h000000_FFFFFF));
    add_segment(pack_segment(-4096, -4096, 4096, 4096, 48'hFF0000_0000FF));
    add_segment(pack_segment(-32768, -32768, 32767, 32767, 48'h000000_FFFFFF));
    add_segment(pack_segment(32767, -32768, -32768, 32767, 48'hFFFFFF_000000));
    add_segment(pack_segment(-32768, 0, -32768, 100, 48'h00FF00_FF00FF));
    add_segment(pack_segment(32767, 32767, 32767, 32767, 48'h000000_000000));
    add_segment(pack_segment(-8192, 4096, 0, 12288, 48'h112233_445566));
    add_segment(pack_segment(3, -9000, -3, 9000, 48'hFEDCBA_012345));
    add_segment(pack_segment(-4097, 0, 4097, 1, 48'h7F7F7F_808080));
    // Random: mostly near the window, some anywhere in the full range.
    for (int k = 0; k < N_RANDOM; k++) begin
      hues = 48'({$urandom, $urandom});
      if ($urandom_range(0, 3) == 0)
        add_segment({hues, 32'($urandom), 32'($urandom)});
      else if ($urandom_range(0, 9) == 0)
        add_segment(pack_segment(near_coord(), 4096, near_coord(), 4096, hues));
      else
        add_segment(pack_segment(near_coord(), near_coord(),
                                 near_coord(), near_coord(), hues));
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (segments_q.size() == 0 && !s_tvalid && clipped_q.size() == 0);
    repeat (60) @(posedge clk);
    $display("Clipped %0d segments (%0d visible, %0d rejected) with random stalls on both sides.",
             n_got, n_seen, n_got - n_seen);
    if (errors == 0 && clipped_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
